@@ rtl/core/bfba_pkg.sv @@
// bfba_pkg: shared types and constants of the best-fit block allocator
// holds action codes, controller states, datapath commands and status
// no dependencies
`default_nettype none

package bfba_pkg;

    // section limits and table size default
    localparam int unsigned TABLE_ENTRIES_DEF = 256;
    localparam logic [24:0] EXT_MAX = 25'd16777216;
    localparam logic [19:0] LOW_MAX = 20'd524288;
    localparam int unsigned SEC_MIN = 16;

    // request actions
    typedef enum logic [1:0] {
        ACT_ALLOC     = 2'd0,
        ACT_ALLOC_LOW = 2'd1,
        ACT_FREE      = 2'd2,
        ACT_SHRINK    = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic CFG_EXT = 1'b0;
    localparam logic CFG_LOW = 1'b1;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN_START,
        CMD_CLR,
        CMD_SEEK_EXT,
        CMD_SEEK_LOW,
        CMD_FIND_START,
        CMD_RD,
        CMD_SEARCH,
        CMD_FIND,
        CMD_SCAN_RD,
        CMD_SCAN_CHK,
        CMD_WR_TAIL,
        CMD_WR_HEAD,
        CMD_WR_BUSY,
        CMD_WR_FREE,
        CMD_OK,
        CMD_FIN_START,
        CMD_FIN_STEP,
        CMD_FIN_END,
        CMD_EMIT
    } t_cmd;

    // controller states
    typedef enum logic [4:0] {
        S_CLR_INIT,
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_EV,
        S_SRCH_DONE,
        S_FIND_RD,
        S_FIND_EV,
        S_FIND_DONE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_TAIL,
        S_SPLIT_HEAD,
        S_OK,
        S_FIN_INIT,
        S_FIN_RD,
        S_FIN_EV,
        S_FIN_END,
        S_EMIT
    } t_state;

    // datapath status toward the controller
    typedef struct packed {
        t_action act;
        logic    size_zero;
        logic    cur_end;
        logic    scan_done;
        logic    sel_ok;
        logic    spare_ok;
        logic    fit_exact;
        logic    fit_less;
        logic    sec_low;
        logic    out_free;
        logic    cfg_wr;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/bfba_req_if.sv @@
// bfba_req_if: request channel of the allocator
// valid/ready handshake with action, size and address; uses no package
`default_nettype none

interface bfba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [24:0] req_size;
    logic [24:0] address;

    modport source (output valid, output action, output req_size, output address,
                    input ready);
    modport sink   (input valid, input action, input req_size, input address,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/bfba_rsp_if.sv @@
// bfba_rsp_if: result channel of the allocator
// valid/ready handshake with status, address and free statistics; uses no package
`default_nettype none

interface bfba_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [24:0] block_address;
    logic [24:0] free_bytes;
    logic [24:0] largest_free;

    modport source (output valid, output status, output block_address,
                    output free_bytes, output largest_free, input ready);
    modport sink   (input valid, input status, input block_address,
                    input free_bytes, input largest_free, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bfba_ram.sv @@
// bfba_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module bfba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/bfba_dp.sv @@
// bfba_dp: allocator datapath: arena table memory, walk registers, output register
// depends on bfba_pkg and bfba_ram
`default_nettype none

module bfba_dp #(
    parameter int unsigned TABLE_ENTRIES = bfba_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bfba_pkg::t_cmd i_cmd,
    output bfba_pkg::t_stat     o_stat,
    input  wire logic           i_cfg_wr_en,
    input  wire logic           i_cfg_index,
    input  wire logic [24:0]    i_cfg_wdata,
    input  wire logic [1:0]     i_action,
    input  wire logic [24:0]    i_req_size,
    input  wire logic [24:0]    i_address,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_status,
    output logic [24:0]         o_block_address,
    output logic [24:0]         o_free_bytes,
    output logic [24:0]         o_largest_free
);
    import bfba_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned IW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned EW = 25 + 25 + 2 + IW;
    localparam logic [IW-1:0] NONE = IW'(TABLE_ENTRIES);

    // configuration
    logic [24:0] r_ext;
    logic [19:0] r_low;
    logic [24:0] n_ext;
    logic [19:0] n_low;

    // request
    t_action     r_action;
    logic [24:0] r_size;
    logic [24:0] r_addr_in;
    logic [25:0] r_want;
    logic        r_sec;
    logic [25:0] sz4;
    logic [25:0] sz16;

    // walk and selection
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_scan;
    logic [AW-1:0] r_spare;
    logic          r_spare_ok;
    logic [25:0]   r_best_len;
    logic          r_sel_ok;
    logic [AW-1:0] r_sel_idx;
    logic [24:0]   r_sel_start;
    logic [24:0]   r_sel_len;
    logic          r_sel_low;
    logic [IW-1:0] r_sel_next;

    // final walk hold entry and statistics
    logic          r_hold_valid;
    logic [AW-1:0] r_hold_idx;
    logic [24:0]   r_hold_start;
    logic [24:0]   r_hold_len;
    logic          r_hold_busy;
    logic          r_hold_low;
    logic [IW-1:0] r_hold_next;
    logic [24:0]   r_total;
    logic [24:0]   r_largest;
    logic          r_ok;
    logic [24:0]   r_addr;

    // output register
    logic          r_out_valid;
    logic          r_o_status;
    logic [24:0]   r_o_addr;
    logic [24:0]   r_o_free;
    logic [24:0]   r_o_largest;

    // memory ports
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [EW-1:0] rdata;

    logic [24:0]   rd_start;
    logic [24:0]   rd_len;
    logic          rd_busy;
    logic          rd_low;
    logic [IW-1:0] rd_next;
    logic          fit;
    logic          merge;
    logic [EW-1:0] clr_entry;
    logic [EW-1:0] hold_entry;

    bfba_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // entry fields
    assign rd_start = rdata[EW-1 -: 25];
    assign rd_len   = rdata[EW-26 -: 25];
    assign rd_busy  = rdata[IW+1];
    assign rd_low   = rdata[IW];
    assign rd_next  = rdata[IW-1:0];

    // rounded sizes
    assign sz4  = ({1'b0, r_size} + 26'd3) & ~26'd3;
    assign sz16 = ({1'b0, r_size} + 26'd15) & ~26'd15;

    assign fit = !rd_busy && (rd_low == r_sec) && (r_want <= {1'b0, rd_len})
                 && ({1'b0, rd_len} < r_best_len);
    assign merge = !r_hold_busy && !rd_busy && (r_hold_low == rd_low);

    // rebuild content of one slot
    always_comb begin
        if (r_scan == IW'(0)) begin
            clr_entry = {25'd0, r_ext, 1'b0, 1'b0, IW'(1)};
        end else if (r_scan == IW'(1)) begin
            clr_entry = {r_ext, {5'd0, r_low}, 1'b0, 1'b1, NONE};
        end else begin
            clr_entry = {25'd0, 25'd0, 1'b0, 1'b0, NONE};
        end
    end

    assign hold_entry = {r_hold_start, r_hold_len, r_hold_busy, r_hold_low, r_hold_next};

    // memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_sel_idx;
        wdata = {r_sel_start, r_sel_len, 1'b1, r_sel_low, r_sel_next};
        raddr = r_cur[AW-1:0];
        unique case (i_cmd)
            CMD_CLR: begin
                we    = 1'b1;
                waddr = r_scan[AW-1:0];
                wdata = clr_entry;
            end
            CMD_SCAN_RD: begin
                raddr = r_scan[AW-1:0];
            end
            CMD_WR_TAIL: begin
                we    = 1'b1;
                waddr = r_spare;
                wdata = {r_sel_start + r_want[24:0], r_sel_len - r_want[24:0],
                         1'b0, r_sel_low, r_sel_next};
            end
            CMD_WR_HEAD: begin
                we    = 1'b1;
                wdata = {r_sel_start, r_want[24:0], 1'b1, r_sel_low, IW'(r_spare)};
            end
            CMD_WR_BUSY: begin
                we = 1'b1;
            end
            CMD_WR_FREE: begin
                we    = 1'b1;
                wdata = {r_sel_start, r_sel_len, 1'b0, r_sel_low, r_sel_next};
            end
            CMD_FIN_STEP: begin
                if (r_hold_valid && merge) begin
                    we    = 1'b1;
                    waddr = r_cur[AW-1:0];
                    wdata = {25'd0, 25'd0, 1'b0, 1'b0, NONE};
                end else if (r_hold_valid) begin
                    we    = 1'b1;
                    waddr = r_hold_idx;
                    wdata = hold_entry;
                end
            end
            CMD_FIN_END: begin
                we    = r_hold_valid;
                waddr = r_hold_idx;
                wdata = hold_entry;
            end
            default: begin
            end
        endcase
    end

    // configuration values, rounded and limited
    always_comb begin
        n_ext = i_cfg_wdata & ~25'd15;
        if (n_ext < 25'(SEC_MIN)) begin
            n_ext = 25'(SEC_MIN);
        end else if (n_ext > EXT_MAX) begin
            n_ext = EXT_MAX;
        end
        n_low = i_cfg_wdata[19:0] & ~20'd15;
        if (n_low < 20'(SEC_MIN)) begin
            n_low = 20'(SEC_MIN);
        end else if (n_low > LOW_MAX) begin
            n_low = LOW_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= EXT_MAX;
            r_low <= LOW_MAX;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_EXT) begin
                r_ext <= n_ext;
            end else begin
                r_low <= n_low;
            end
        end
    end

    // request, walk and statistics registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_action  <= t_action'(i_action);
                r_size    <= i_req_size;
                r_addr_in <= i_address;
                r_ok      <= 1'b0;
                r_addr    <= 25'd0;
            end
            CMD_SCAN_START: begin
                r_scan     <= '0;
                r_spare_ok <= 1'b0;
            end
            CMD_CLR: begin
                r_scan <= r_scan + IW'(1);
            end
            CMD_SEEK_EXT, CMD_SEEK_LOW: begin
                r_cur      <= '0;
                r_sel_ok   <= 1'b0;
                r_best_len <= '1;
                r_sec      <= (i_cmd == CMD_SEEK_LOW);
                r_want     <= (i_cmd == CMD_SEEK_LOW) ? sz16 : sz4;
            end
            CMD_FIND_START: begin
                r_cur    <= '0;
                r_sel_ok <= 1'b0;
                r_want   <= sz4;
            end
            CMD_SEARCH: begin
                if (fit) begin
                    r_sel_ok    <= 1'b1;
                    r_best_len  <= {1'b0, rd_len};
                    r_sel_idx   <= r_cur[AW-1:0];
                    r_sel_start <= rd_start;
                    r_sel_len   <= rd_len;
                    r_sel_low   <= rd_low;
                    r_sel_next  <= rd_next;
                end
                r_cur <= rd_next;
            end
            CMD_FIND: begin
                if (!r_sel_ok && rd_start == r_addr_in) begin
                    r_sel_ok    <= 1'b1;
                    r_sel_idx   <= r_cur[AW-1:0];
                    r_sel_start <= rd_start;
                    r_sel_len   <= rd_len;
                    r_sel_low   <= rd_low;
                    r_sel_next  <= rd_next;
                end
                r_cur <= rd_next;
            end
            CMD_SCAN_CHK: begin
                if (rd_len == 25'd0) begin
                    r_spare_ok <= 1'b1;
                    r_spare    <= r_scan[AW-1:0];
                end else begin
                    r_scan <= r_scan + IW'(1);
                end
            end
            CMD_OK: begin
                r_ok <= 1'b1;
                if (r_action == ACT_ALLOC || r_action == ACT_ALLOC_LOW) begin
                    r_addr <= r_sel_start;
                end
            end
            CMD_FIN_START: begin
                r_cur        <= '0;
                r_hold_valid <= 1'b0;
                r_total      <= 25'd0;
                r_largest    <= 25'd0;
            end
            CMD_FIN_STEP: begin
                if (r_hold_valid && merge) begin
                    r_hold_len  <= r_hold_len + rd_len;
                    r_hold_next <= rd_next;
                end else begin
                    if (r_hold_valid && !r_hold_busy) begin
                        r_total <= r_total + r_hold_len;
                        if (r_hold_len > r_largest) begin
                            r_largest <= r_hold_len;
                        end
                    end
                    r_hold_valid <= 1'b1;
                    r_hold_idx   <= r_cur[AW-1:0];
                    r_hold_start <= rd_start;
                    r_hold_len   <= rd_len;
                    r_hold_busy  <= rd_busy;
                    r_hold_low   <= rd_low;
                    r_hold_next  <= rd_next;
                end
                r_cur <= rd_next;
            end
            CMD_FIN_END: begin
                if (r_hold_valid && !r_hold_busy) begin
                    r_total <= r_total + r_hold_len;
                    if (r_hold_len > r_largest) begin
                        r_largest <= r_hold_len;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_EMIT) begin
            r_o_status  <= !r_ok;
            r_o_addr    <= r_addr;
            r_o_free    <= r_total & ~25'd3;
            r_o_largest <= r_largest & ~25'd3;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_block_address = r_o_addr;
    assign o_free_bytes    = r_o_free;
    assign o_largest_free  = r_o_largest;

    // status toward the controller
    assign o_stat.act       = r_action;
    assign o_stat.size_zero = (r_size == 25'd0);
    assign o_stat.cur_end   = (r_cur == NONE);
    assign o_stat.scan_done = (r_scan == NONE);
    assign o_stat.sel_ok    = r_sel_ok;
    assign o_stat.spare_ok  = r_spare_ok;
    assign o_stat.fit_exact = (r_want == {1'b0, r_sel_len});
    assign o_stat.fit_less  = (r_want < {1'b0, r_sel_len});
    assign o_stat.sec_low   = r_sec;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.cfg_wr    = i_cfg_wr_en;

    // split tail never lands on the arena being split
    a_tail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_WR_TAIL |-> r_spare_ok && (r_spare != r_sel_idx))
        else $error("split tail slot collides with split arena");

    // a merge only grows a free hold arena
    a_merge_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_FIN_STEP && r_hold_valid && merge) |-> !r_hold_busy && !rd_busy)
        else $error("merge of a busy arena");

    // largest free block never exceeds the free total at result time
    a_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_EMIT |-> r_largest <= r_total)
        else $error("largest free block above free total");

    // a new result is only loaded into a free output register
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_EMIT && r_out_valid) |-> i_out_ready)
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

@@ rtl/core/bfba_ctrl.sv @@
// bfba_ctrl: allocator controller state machine
// sequences search, find, spare scan, split, final walk and result; uses bfba_pkg
`default_nettype none

module bfba_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire bfba_pkg::t_stat i_stat,
    output bfba_pkg::t_cmd       o_cmd
);
    import bfba_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;
    logic   can_fall_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // allocate falls back to the low section once
    assign can_fall_back = (i_stat.act == ACT_ALLOC) && !i_stat.sec_low;

    always_comb begin
        n_state = r_state;
        cmd     = CMD_NONE;
        unique case (r_state)
            S_CLR_INIT: begin
                cmd     = CMD_SCAN_START;
                n_state = S_CLR;
            end
            S_CLR: begin
                if (i_stat.scan_done) begin
                    n_state = S_IDLE;
                end else begin
                    cmd = CMD_CLR;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd     = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.act == ACT_FREE || i_stat.act == ACT_SHRINK) begin
                    cmd     = CMD_FIND_START;
                    n_state = S_FIND_RD;
                end else if (i_stat.size_zero) begin
                    n_state = S_FIN_INIT;
                end else if (i_stat.act == ACT_ALLOC) begin
                    cmd     = CMD_SEEK_EXT;
                    n_state = S_SRCH_RD;
                end else begin
                    cmd     = CMD_SEEK_LOW;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_stat.cur_end) begin
                    n_state = S_SRCH_DONE;
                end else begin
                    cmd     = CMD_RD;
                    n_state = S_SRCH_EV;
                end
            end
            S_SRCH_EV: begin
                cmd     = CMD_SEARCH;
                n_state = S_SRCH_RD;
            end
            S_SRCH_DONE: begin
                priority if (!i_stat.sel_ok) begin
                    if (can_fall_back) begin
                        cmd     = CMD_SEEK_LOW;
                        n_state = S_SRCH_RD;
                    end else begin
                        n_state = S_FIN_INIT;
                    end
                end else if (i_stat.fit_exact) begin
                    cmd     = CMD_WR_BUSY;
                    n_state = S_OK;
                end else begin
                    cmd     = CMD_SCAN_START;
                    n_state = S_SCAN_RD;
                end
            end
            S_FIND_RD: begin
                if (i_stat.cur_end || i_stat.sel_ok) begin
                    n_state = S_FIND_DONE;
                end else begin
                    cmd     = CMD_RD;
                    n_state = S_FIND_EV;
                end
            end
            S_FIND_EV: begin
                cmd     = CMD_FIND;
                n_state = S_FIND_RD;
            end
            S_FIND_DONE: begin
                priority if (!i_stat.sel_ok) begin
                    n_state = S_FIN_INIT;
                end else if (i_stat.act == ACT_FREE) begin
                    cmd     = CMD_WR_FREE;
                    n_state = S_OK;
                end else if (i_stat.size_zero) begin
                    n_state = S_FIN_INIT;
                end else if (i_stat.fit_exact) begin
                    n_state = S_OK;
                end else if (i_stat.fit_less) begin
                    cmd     = CMD_SCAN_START;
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_FIN_INIT;
                end
            end
            S_SCAN_RD: begin
                priority if (i_stat.spare_ok) begin
                    n_state = S_SPLIT_TAIL;
                end else if (i_stat.scan_done) begin
                    // table full
                    if (i_stat.act == ACT_SHRINK) begin
                        cmd     = CMD_WR_BUSY;
                        n_state = S_FIN_INIT;
                    end else if (can_fall_back) begin
                        cmd     = CMD_SEEK_LOW;
                        n_state = S_SRCH_RD;
                    end else begin
                        n_state = S_FIN_INIT;
                    end
                end else begin
                    cmd     = CMD_SCAN_RD;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                cmd     = CMD_SCAN_CHK;
                n_state = S_SCAN_RD;
            end
            S_SPLIT_TAIL: begin
                cmd     = CMD_WR_TAIL;
                n_state = S_SPLIT_HEAD;
            end
            S_SPLIT_HEAD: begin
                cmd     = CMD_WR_HEAD;
                n_state = S_OK;
            end
            S_OK: begin
                cmd     = CMD_OK;
                n_state = S_FIN_INIT;
            end
            S_FIN_INIT: begin
                cmd     = CMD_FIN_START;
                n_state = S_FIN_RD;
            end
            S_FIN_RD: begin
                if (i_stat.cur_end) begin
                    n_state = S_FIN_END;
                end else begin
                    cmd     = CMD_RD;
                    n_state = S_FIN_EV;
                end
            end
            S_FIN_EV: begin
                cmd     = CMD_FIN_STEP;
                n_state = S_FIN_RD;
            end
            S_FIN_END: begin
                cmd     = CMD_FIN_END;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    cmd     = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR_INIT;
            end
        endcase
        // a register write rebuilds the table
        if (i_stat.cfg_wr) begin
            cmd     = CMD_NONE;
            n_state = S_CLR_INIT;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE) && !i_stat.cfg_wr;

    // an accepted request always starts with a load
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> cmd == CMD_LOAD)
        else $error("request transfer without load");

    // after a load the request is dispatched
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == CMD_LOAD) |=> (r_state == S_DISPATCH || r_state == S_CLR_INIT))
        else $error("load not followed by dispatch");

    // table writes only while busy with a request or rebuilding
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (cmd == CMD_NONE || cmd == CMD_LOAD))
        else $error("command issued while idle");

endmodule

`default_nettype wire

@@ rtl/core/best_fit_block_allocator.sv @@
// best_fit_block_allocator: top level of the best-fit block allocator
// joins bfba_ctrl and bfba_dp to the request/result interfaces and the register port
//
// Usage: requests arrive on i_req (action, req_size, address) with valid/ready; one result
// per request leaves on o_rsp (status, block_address, free_bytes, largest_free). A transfer
// happens on a rising edge with valid and ready both high. Registers extended_bytes (index 0)
// and low_bytes (index 1) are written through i_cfg_wr_en/i_cfg_index/i_cfg_wdata, by the
// user only while idle; the block itself does not enforce this. Reset and every register
// write rebuild the arena table in a clearing pass during which no request is taken.
// One request is worked at a time. Each list walk visits one arena at a time, a memory read
// then an evaluate, as the arena table has a single read port. A request runs the search or
// address find over the list, a spare-slot scan over the table on a split, the table writes,
// and the final merge and statistics walk over the list; allocate with low fallback may
// search and scan twice. A zero-size allocate goes straight to the final walk; the longest
// requests are allocates that scan a full table in both sections.
// The result sits in an output register; a new request is taken as soon as that register
// holds the result, and if the receiver stalls, the next result waits until it drains.
`default_nettype none

module best_fit_block_allocator #(
    parameter int unsigned TABLE_ENTRIES = bfba_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bfba_req_if.sink         i_req,
    bfba_rsp_if.source       o_rsp,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [24:0] i_cfg_wdata
);
    import bfba_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    bfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfba_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_req.action),
        .i_req_size      (i_req.req_size),
        .i_address       (i_req.address),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_block_address (o_rsp.block_address),
        .o_free_bytes    (o_rsp.free_bytes),
        .o_largest_free  (o_rsp.largest_free)
    );

    assign i_req.ready = in_ready;

endmodule

`default_nettype wire
